// File: design/mmh_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and queue entry format for the murmur3 128-bit hash core
// no dependencies

package mmh_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [63:0] MixC1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MixC2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] AddH1 = 64'h0000000052dce729;
  localparam logic [63:0] AddH2 = 64'h0000000038495ab5;
  localparam logic [63:0] FinM1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FinM2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [3:0] WordBytes = 4'd8;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_low;
    logic [63:0] hash_high;
    logic        ok;
  } out_item_t;

  // classified work for the back end
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        hold;
    logic        do_k1;
    logic        k1_held;
    logic        do_k2;
    logic        do_mix;
  } q_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

endpackage

// File: design/mmh_front.sv
`timescale 1ns / 1ps
// front end: accepts words, masks the last word and classifies each transfer
// depends on mmh_pkg

module mmh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mmh_pkg::in_item_t in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output mmh_pkg::q_entry_t push_entry_o
);
  import mmh_pkg::*;

  logic       held_q, held_d;
  logic [3:0] nv;
  logic       accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  always_comb begin
    nv = (in_data_i.valid_bytes > WordBytes) ? WordBytes : in_data_i.valid_bytes;
    push_entry_o         = '0;
    push_entry_o.word    = in_data_i.data_word;
    push_entry_o.last    = in_data_i.last;
    if (!in_data_i.last) begin
      push_entry_o.nbytes = WordBytes;
      if (held_q) begin
        push_entry_o.do_mix  = 1'b1;
        push_entry_o.do_k1   = 1'b1;
        push_entry_o.k1_held = 1'b1;
        push_entry_o.do_k2   = 1'b1;
      end else begin
        push_entry_o.hold = 1'b1;
      end
    end else begin
      push_entry_o.nbytes = nv;
      for (int i = 0; i < 8; i++) begin
        if (4'(i) >= nv) begin
          push_entry_o.word[8*i +: 8] = 8'h00;
        end
      end
      if (held_q) begin
        push_entry_o.do_k1   = 1'b1;
        push_entry_o.k1_held = 1'b1;
        push_entry_o.do_k2   = (nv != 4'd0);
        push_entry_o.do_mix  = (nv == WordBytes);
      end else begin
        push_entry_o.do_k1 = (nv != 4'd0);
      end
    end
  end

  always_comb begin
    held_d = held_q;
    if (accept) begin
      held_d = in_data_i.last ? 1'b0 : !held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else begin
      held_q <= held_d;
    end
  end

endmodule

// File: design/mmh_queue.sv
`timescale 1ns / 1ps
// short queue between the front end and the back end
// depends on mmh_pkg

module mmh_queue #(
  parameter int unsigned Depth = mmh_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  mmh_pkg::q_entry_t push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output mmh_pkg::q_entry_t pop_entry_o
);
  import mmh_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t            slot_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_entry_i;
    end
  end

endmodule

// File: design/mmh_mul64.sv
`timescale 1ns / 1ps
// low half of a 64 by 64 product from three 32 by 32 partial products
// depends on mmh_pkg

module mmh_mul64 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmh_pkg::mul_req_t req_i,
  output mmh_pkg::mul_rsp_t rsp_o
);
  import mmh_pkg::*;

  localparam logic [1:0] StepLoLo = 2'd0;
  localparam logic [1:0] StepLoHi = 2'd1;
  localparam logic [1:0] StepLast = 2'd3;

  logic [63:0] a_q, b_q, pp_q, acc_q, prod, addend;
  logic [31:0] x, y;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;

  always_comb begin
    case (cnt_q)
      StepLoLo: begin
        x = a_q[31:0];
        y = b_q[31:0];
      end
      StepLoHi: begin
        x = a_q[31:0];
        y = b_q[63:32];
      end
      default: begin
        x = a_q[63:32];
        y = b_q[31:0];
      end
    endcase
    prod   = 64'(x) * 64'(y);
    addend = (cnt_q == StepLoHi) ? pp_q : {pp_q[31:0], 32'h0};
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == StepLast);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= StepLoLo;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepLast) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q <= prod;
      if (cnt_q != StepLoLo) begin
        acc_q <= acc_q + addend;
      end
    end
  end

endmodule

// File: design/mmh_back.sv
`timescale 1ns / 1ps
// back end: key mix, body mix, tail and finalisation sequencer with output register
// depends on mmh_pkg and a mmh_mul64 unit through mul_req_t / mul_rsp_t

module mmh_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  mmh_pkg::q_entry_t  pop_entry_i,
  output mmh_pkg::mul_req_t  mul_req_o,
  input  mmh_pkg::mul_rsp_t  mul_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mmh_pkg::out_item_t out_data_o
);
  import mmh_pkg::*;

  typedef enum logic [20:0] {
    ST_IDLE = 21'h000001,
    ST_K1A  = 21'h000002,
    ST_K1B  = 21'h000004,
    ST_K2A  = 21'h000008,
    ST_K2B  = 21'h000010,
    ST_MXA  = 21'h000020,
    ST_MXB  = 21'h000040,
    ST_MXC  = 21'h000080,
    ST_MXD  = 21'h000100,
    ST_FNA  = 21'h000200,
    ST_FNB  = 21'h000400,
    ST_FNC  = 21'h000800,
    ST_F1A  = 21'h001000,
    ST_F1B  = 21'h002000,
    ST_F1C  = 21'h004000,
    ST_F2A  = 21'h008000,
    ST_F2B  = 21'h010000,
    ST_F2C  = 21'h020000,
    ST_FND  = 21'h040000,
    ST_FNE  = 21'h080000,
    ST_OUT  = 21'h100000
  } state_e;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  state_e      state_q, state_d;
  logic        pend_q, pend_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic [63:0] acc1_q, acc1_d, acc2_q, acc2_d, held_q, held_d, tot_q, tot_d;
  q_entry_t    cur_q, cur_d;
  logic [63:0] t_q, t_d, k1_q, k1_d, k2_q, k2_d, h1_q, h1_d, h2_q, h2_d;
  logic        ok_q, ok_d;
  logic        mul_state, mul_ack;
  logic [63:0] p;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign p           = mul_rsp_i.p;
  assign mul_ack     = pend_q && mul_rsp_i.done;

  // operand selection for the shared multiplier
  always_comb begin
    mul_state = state_q inside {ST_K1A, ST_K1B, ST_K2A, ST_K2B, ST_F1B, ST_F1C,
                                ST_F2B, ST_F2C};
    mul_req_o.start = mul_state && !pend_q;
    case (state_q)
      ST_K1A: begin
        mul_req_o.a = cur_q.k1_held ? held_q : cur_q.word;
        mul_req_o.b = MixC1;
      end
      ST_K1B: begin
        mul_req_o.a = t_q;
        mul_req_o.b = MixC2;
      end
      ST_K2A: begin
        mul_req_o.a = cur_q.word;
        mul_req_o.b = MixC2;
      end
      ST_K2B: begin
        mul_req_o.a = t_q;
        mul_req_o.b = MixC1;
      end
      ST_F1B: begin
        mul_req_o.a = h1_q;
        mul_req_o.b = FinM1;
      end
      ST_F1C: begin
        mul_req_o.a = h1_q;
        mul_req_o.b = FinM2;
      end
      ST_F2B: begin
        mul_req_o.a = h2_q;
        mul_req_o.b = FinM1;
      end
      ST_F2C: begin
        mul_req_o.a = h2_q;
        mul_req_o.b = FinM2;
      end
      default: begin
        mul_req_o.a = '0;
        mul_req_o.b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    acc1_d      = acc1_q;
    acc2_d      = acc2_q;
    held_d      = held_q;
    tot_d       = tot_q;
    cur_d       = cur_q;
    t_d         = t_q;
    k1_d        = k1_q;
    k2_d        = k2_q;
    h1_d        = h1_q;
    h2_d        = h2_q;
    ok_d        = ok_q;
    pop_ready_o = 1'b0;

    if (mul_req_o.start) begin
      pend_d = 1'b1;
    end else if (mul_ack) begin
      pend_d = 1'b0;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          tot_d = tot_q + 64'(pop_entry_i.nbytes);
          if (pop_entry_i.hold) begin
            held_d = pop_entry_i.word;
          end else begin
            cur_d = pop_entry_i;
            if (pop_entry_i.do_k1) begin
              state_d = ST_K1A;
            end else if (pop_entry_i.do_k2) begin
              state_d = ST_K2A;
            end else begin
              state_d = ST_FNA;
            end
          end
        end
      end
      ST_K1A: begin
        if (mul_ack) begin
          t_d     = rotl(p, 31);
          state_d = ST_K1B;
        end
      end
      ST_K1B: begin
        if (mul_ack) begin
          if (cur_q.do_mix) begin
            k1_d = p;
          end else begin
            acc1_d = acc1_q ^ p;
          end
          state_d = cur_q.do_k2 ? ST_K2A : ST_FNA;
        end
      end
      ST_K2A: begin
        if (mul_ack) begin
          t_d     = rotl(p, 33);
          state_d = ST_K2B;
        end
      end
      ST_K2B: begin
        if (mul_ack) begin
          if (cur_q.do_mix) begin
            k2_d    = p;
            state_d = ST_MXA;
          end else begin
            acc2_d  = acc2_q ^ p;
            state_d = ST_FNA;
          end
        end
      end
      ST_MXA: begin
        acc1_d  = rotl(acc1_q ^ k1_q, 27) + acc2_q;
        state_d = ST_MXB;
      end
      ST_MXB: begin
        acc1_d  = {acc1_q[61:0], 2'b00} + acc1_q + AddH1;
        state_d = ST_MXC;
      end
      ST_MXC: begin
        acc2_d  = rotl(acc2_q ^ k2_q, 31) + acc1_q;
        state_d = ST_MXD;
      end
      ST_MXD: begin
        acc2_d  = {acc2_q[61:0], 2'b00} + acc2_q + AddH2;
        state_d = cur_q.last ? ST_FNA : ST_IDLE;
      end
      ST_FNA: begin
        // empty message gives zero hashes and ok low
        if (tot_q == '0) begin
          h1_d    = '0;
          h2_d    = '0;
          ok_d    = 1'b0;
          state_d = ST_OUT;
        end else begin
          h1_d    = acc1_q ^ tot_q;
          h2_d    = acc2_q ^ tot_q;
          ok_d    = 1'b1;
          state_d = ST_FNB;
        end
      end
      ST_FNB: begin
        h1_d    = h1_q + h2_q;
        state_d = ST_FNC;
      end
      ST_FNC: begin
        h2_d    = h2_q + h1_q;
        state_d = ST_F1A;
      end
      ST_F1A: begin
        h1_d    = h1_q ^ (h1_q >> 33);
        state_d = ST_F1B;
      end
      ST_F1B: begin
        if (mul_ack) begin
          h1_d    = p ^ (p >> 33);
          state_d = ST_F1C;
        end
      end
      ST_F1C: begin
        if (mul_ack) begin
          h1_d    = p ^ (p >> 33);
          state_d = ST_F2A;
        end
      end
      ST_F2A: begin
        h2_d    = h2_q ^ (h2_q >> 33);
        state_d = ST_F2B;
      end
      ST_F2B: begin
        if (mul_ack) begin
          h2_d    = p ^ (p >> 33);
          state_d = ST_F2C;
        end
      end
      ST_F2C: begin
        if (mul_ack) begin
          h2_d    = p ^ (p >> 33);
          state_d = ST_FND;
        end
      end
      ST_FND: begin
        h1_d    = h1_q + h2_q;
        state_d = ST_FNE;
      end
      ST_FNE: begin
        h2_d    = h2_q + h1_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          out_d.hash_low  = h1_q;
          out_d.hash_high = h2_q;
          out_d.ok        = ok_q;
          acc1_d          = '0;
          acc2_d          = '0;
          tot_d           = '0;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      acc1_q      <= '0;
      acc2_q      <= '0;
      held_q      <= '0;
      tot_q       <= '0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      acc1_q      <= acc1_d;
      acc2_q      <= acc2_d;
      held_q      <= held_d;
      tot_q       <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    cur_q <= cur_d;
    t_q   <= t_d;
    k1_q  <= k1_d;
    k2_q  <= k2_d;
    h1_q  <= h1_d;
    h2_q  <= h2_d;
    ok_q  <= ok_d;
  end

endmodule

// File: design/murmur3_128_hash_core.sv
`timescale 1ns / 1ps
// top level of the streaming murmur3 x64 128-bit hash core, seed zero
// depends on mmh_pkg, mmh_front, mmh_queue, mmh_mul64 and mmh_back

// Words enter as little-endian 64-bit transfers; the word marked last closes the message and
// produces one transfer carrying h1, h2 and ok. The front end classifies words in the cycle
// they arrive and parks them in a short queue, so input keeps flowing, until the queue is full,
// while the back end works. All 64-bit multiplies share one 32 by 32 multiplier, and that unit
// sets the pace: a word that only opens a block is just held, a word that completes a block runs
// both key mixes and the body mix, and the last word adds the finalisation. The finished hash
// waits in an output register while the next message starts.
module murmur3_128_hash_core #(
  parameter int unsigned QueueDepth = mmh_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mmh_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mmh_pkg::out_item_t out_data_o
);
  import mmh_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t push_entry, pop_entry;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  mmh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  mmh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  mmh_mul64 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  mmh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/mmh_checker.sv
`timescale 1ns / 1ps
// port-level checks for the murmur3 128-bit hash core, bound to the top level
// depends on mmh_pkg and murmur3_128_hash_core

module mmh_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input mmh_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mmh_pkg::out_item_t out_data_o
);
  import mmh_pkg::*;

  // messages closed at the input and not yet delivered
  logic [3:0] open_q;
  logic       last_in, res_out;

  assign last_in = in_valid_i && in_ready_o && in_data_i.last;
  assign res_out = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (last_in && !res_out) begin
      open_q <= open_q + 1'b1;
    end else if (res_out && !last_in) begin
      open_q <= open_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.hash_low == '0 &&
                                      out_data_o.hash_high == '0)
    else $error("empty message with nonzero hash");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> open_q != '0)
    else $error("result without a closed message");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 4'(QueueDepth + 2))
    else $error("more messages in flight than the core can hold");

endmodule

bind murmur3_128_hash_core mmh_checker u_mmh_checker (.*);
